>>> src/sorted_set_table_top_defines.svh
// ----------------------------------------------------------------------------
// sorted set table assertion macros
// shared concurrent assertion forms for the sorted set table rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_TOP_DEFINES_SVH
`define SORTED_SET_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sorted set table package
// sizes, command and status codes, and the cell control bundle
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int Depth  = 64;
  localparam int KeyW   = 32;
  localparam int CntW   = $clog2(Depth + 1);
  localparam int PosW   = 6;
  localparam int IdxW   = $clog2(Depth);
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic            cmp_en;
    key_t            cmp_key;
    logic            ins_en;
    logic            rem_en;
    key_t            ins_key;
    logic [CntW-1:0] count;
  } cell_ctrl_t;

endpackage

>>> src/sorted_set_table_top.sv
// ----------------------------------------------------------------------------
// sorted set table top
// ascending duplicate-free key set kept in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// On acceptance of a request every cell compares its key with the request key
// at once, and in the update state the cells shift up or down one place
// together while the result is loaded into the output register. A new
// request is taken once the update state is done; the update state waits only
// while an earlier result is still held in the output register. The capacity
// register is written through the cfg channel.
module sorted_set_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sst_pkg::InDataW-1:0]  in_tdata,   // cmd[1:0], key[33:2], zero pad
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sst_pkg::OutDataW-1:0] out_tdata,  // status[1:0], position[7:2],
                                                   // count[14:8], full_res[15],
                                                   // empty_res[16], zero pad
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [6:0]                   cfg_data
);
  import sst_pkg::*;

  cell_ctrl_t       cell_ctrl;
  logic [Depth-1:0] lt_vec;
  logic [Depth-1:0] eq_vec;
  key_t             entry_vec [Depth];
  logic             idle;
  logic             in_accept;
  status_t          out_status;
  logic [PosW-1:0]  out_position;
  logic [CntW-1:0]  out_count;
  logic             out_full;
  logic             out_empty;

  assign in_tready = idle;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_cmd       (cmd_t'(in_tdata[1:0])),
    .in_key       (key_t'(in_tdata[33:2])),
    .idle         (idle),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_cap      (cfg_data),
    .lt_vec       (lt_vec),
    .eq_vec       (eq_vec),
    .cell_ctrl    (cell_ctrl),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count),
    .out_full     (out_full),
    .out_empty    (out_empty)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    sst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .cell_idx   (IdxW'(i)),
      .prev_entry ((i == 0) ? cell_ctrl.ins_key : entry_vec[(i == 0) ? 0 : i - 1]),
      .prev_lt    ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
      .next_entry (entry_vec[(i == Depth - 1) ? i : i + 1]),
      .entry      (entry_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  assign out_tdata = {7'd0, out_empty, out_full, out_count, out_position, out_status};

endmodule

>>> src/sst_cell.sv
// ----------------------------------------------------------------------------
// sorted set table cell
// holds one key, compares it with a request key and shifts with its neighbors
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sst_pkg::cell_ctrl_t      ctrl,
  input  logic [sst_pkg::IdxW-1:0] cell_idx,
  input  sst_pkg::key_t            prev_entry,
  input  logic                     prev_lt,
  input  sst_pkg::key_t            next_entry,
  output sst_pkg::key_t            entry,
  output logic                     lt,
  output logic                     eq
);
  import sst_pkg::*;

  key_t entry_r, entry_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;
  logic valid;

  assign valid = {1'b0, cell_idx} < ctrl.count;

  always_comb begin
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    if (ctrl.cmp_en) begin
      lt_nxt = valid && (entry_r < ctrl.cmp_key);
      eq_nxt = valid && (entry_r == ctrl.cmp_key);
    end
    if (ctrl.ins_en && !lt_r) begin
      entry_nxt = prev_lt ? ctrl.ins_key : prev_entry;
    end else if (ctrl.rem_en && !lt_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

>>> src/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sorted set table control
// request sequencing, count and capacity, result encoding and output register
// ----------------------------------------------------------------------------
`include "sorted_set_table_top_defines.svh"

module sst_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_accept,
  input  sst_pkg::cmd_t             in_cmd,
  input  sst_pkg::key_t             in_key,
  output logic                      idle,
  input  logic                      cfg_we,
  input  logic [sst_pkg::CntW-1:0]  cfg_cap,
  input  logic [sst_pkg::Depth-1:0] lt_vec,
  input  logic [sst_pkg::Depth-1:0] eq_vec,
  output sst_pkg::cell_ctrl_t       cell_ctrl,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sst_pkg::status_t          out_status,
  output logic [sst_pkg::PosW-1:0]  out_position,
  output logic [sst_pkg::CntW-1:0]  out_count,
  output logic                      out_full,
  output logic                      out_empty
);
  import sst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] cap_r;
  cmd_t            cmd_r;
  key_t            key_r;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] res_count_r;
  logic            full_r, empty_r;

  logic [Depth-1:0] ins_hot;
  logic [PosW-1:0]  lb_pos;
  logic             found;
  logic [CntW-1:0]  eff_cap;
  logic             is_full;
  logic             fire;
  logic             do_ins, do_rem;

  assign eff_cap = (cap_r > CntW'(Depth)) ? CntW'(Depth) : cap_r;
  assign is_full = count_r >= eff_cap;
  assign found   = |eq_vec;
  assign fire    = (state_r == S_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    lb_pos = '0;
    for (int i = 0; i < Depth; i++) begin
      ins_hot[i] = !lt_vec[i] && ((i == 0) || lt_vec[(i == 0) ? 0 : i - 1]);
      lb_pos     = lb_pos | (PosW'(i) & {PosW{ins_hot[i]}});
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    status_nxt = STAT_DONE;
    pos_nxt    = '0;
    count_nxt  = count_r;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (is_full) begin
          status_nxt = STAT_FULL;
        end else if (found) begin
          status_nxt = STAT_DUP;
          pos_nxt    = lb_pos;
        end else begin
          do_ins    = 1'b1;
          pos_nxt   = lb_pos;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        if (found) begin
          pos_nxt = lb_pos;
          if (cmd_r == CMD_REMOVE) begin
            do_rem    = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end else begin
          status_nxt = STAT_ABSENT;
        end
      end
      default: begin
        status_nxt = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CntW'(Depth);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
    end
    if (in_accept) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
    end
    if (fire) begin
      status_r    <= status_nxt;
      pos_r       <= pos_nxt;
      res_count_r <= count_nxt;
      full_r      <= count_nxt >= eff_cap;
      empty_r     <= count_nxt == '0;
    end
  end

  assign idle = (state_r == S_IDLE);

  assign cell_ctrl.cmp_en  = in_accept;
  assign cell_ctrl.cmp_key = in_key;
  assign cell_ctrl.ins_en  = fire && do_ins;
  assign cell_ctrl.rem_en  = fire && do_rem;
  assign cell_ctrl.ins_key = key_r;
  assign cell_ctrl.count   = count_r;

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_count    = res_count_r;
  assign out_full     = full_r;
  assign out_empty    = empty_r;

  `SST_ASSERT_NEXT(a_accept_to_upd, in_accept, state_r == S_UPD, "accept did not start update")
  `SST_ASSERT_NOW(a_count_range, 1'b1, count_r <= CntW'(Depth), "count beyond depth")
  `SST_ASSERT_NOW(a_lb_hot, state_r == S_UPD, $onehot0(ins_hot), "insert point not unique")
  `SST_ASSERT_NOW(a_eq_hot, state_r == S_UPD, $onehot0(eq_vec), "duplicate key stored")
  `SST_ASSERT_NEXT(a_ins_count, cell_ctrl.ins_en, count_r == $past(count_r) + 1'b1, "insert count")

endmodule

>>> tb/sv/sorted_set_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted set table testbench
// drives insert, search and remove requests through the stream ports, keeps
// its own sorted key table to predict each result and compares every field;
// capacity is changed between phases, and both sides idle at random rates
// ----------------------------------------------------------------------------
module sorted_set_table_top_tb;
  import sst_pkg::*;

  typedef struct {
    status_t    status;
    logic [5:0] position;
    logic [6:0] count;
    logic       full;
    logic       empty;
  } set_result_t;

  class sst_scoreboard_t;
    key_t        held[Depth];
    int          held_count;
    int          capacity;
    set_result_t pending[$];
    int          errors;

    function new();
      held_count = 0;
      capacity   = 64;
      errors     = 0;
    endfunction

    function int eff_capacity();
      return (capacity < Depth) ? capacity : Depth;
    endfunction

    // first held key not below the request key
    function int lower_bound(key_t key);
      int i;
      i = 0;
      while (i < held_count && held[i] < key) i++;
      return i;
    endfunction

    function void note_request(cmd_t cmd, key_t key);
      set_result_t r;
      int i;
      r.status   = STAT_DONE;
      r.position = '0;
      case (cmd)
        CMD_INSERT: begin
          if (held_count >= eff_capacity()) begin
            r.status = STAT_FULL;
          end else begin
            i = lower_bound(key);
            if (i < held_count && held[i] == key) begin
              r.status   = STAT_DUP;
              r.position = i[5:0];
            end else begin
              for (int j = held_count; j > i; j--) held[j] = held[j-1];
              held[i] = key;
              held_count++;
              r.position = i[5:0];
            end
          end
        end
        CMD_SEARCH, CMD_REMOVE: begin
          i = lower_bound(key);
          if (i < held_count && held[i] == key) begin
            r.position = i[5:0];
            if (cmd == CMD_REMOVE) begin
              for (int j = i; j + 1 < held_count; j++) held[j] = held[j+1];
              held_count--;
            end
          end else begin
            r.status = STAT_ABSENT;
          end
        end
        default: ;
      endcase
      r.count = held_count[6:0];
      r.full  = (held_count >= eff_capacity());
      r.empty = (held_count == 0);
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      set_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[1:0] !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, data[1:0]);
        errors++;
      end
      if (data[7:2] !== e.position) begin
        $error("position: expected %0d, actual %0d", e.position, data[7:2]);
        errors++;
      end
      if (data[14:8] !== e.count) begin
        $error("count: expected %0d, actual %0d", e.count, data[14:8]);
        errors++;
      end
      if (data[15] !== e.full) begin
        $error("full_res: expected %0d, actual %0d", e.full, data[15]);
        errors++;
      end
      if (data[16] !== e.empty) begin
        $error("empty_res: expected %0d, actual %0d", e.empty, data[16]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data   = '0;

  sst_scoreboard_t sb = new();
  int   send_idle  = 0;
  int   recv_stall = 0;
  key_t key_pool[32];
  key_t corner_keys[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};

  sorted_set_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_request(cmd_t cmd, key_t key);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, key, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, key);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.capacity = value;
  endtask

  // mostly keys that are held or reused, so hits and duplicates are common
  function automatic key_t choose_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && sb.held_count > 0) return sb.held[$urandom_range(sb.held_count - 1)];
    if (r < 75) return key_pool[$urandom_range(31)];
    if (r < 92) return key_t'($urandom);
    return corner_keys[$urandom_range(3)];
  endfunction

  task automatic run_phase(int n, int ins_pct, int srch_pct, bit pause_mid);
    int   r;
    cmd_t cmd;
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) wait_drained();
      r = $urandom_range(99);
      if (r < 2) cmd = CMD_NOP;
      else if (r < 2 + ins_pct) cmd = CMD_INSERT;
      else if (r < 2 + ins_pct + srch_pct) cmd = CMD_SEARCH;
      else cmd = CMD_REMOVE;
      send_request(cmd, choose_key());
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, absent keys, unused command
    send_request(CMD_SEARCH, 32'sd0);
    send_request(CMD_REMOVE, 32'sd5);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, corner_keys[0]);
    send_request(CMD_INSERT, corner_keys[1]);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, 32'sd1);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_SEARCH, corner_keys[1]);
    send_request(CMD_SEARCH, corner_keys[0]);
    send_request(CMD_SEARCH, 32'sd2);
    send_request(CMD_REMOVE, corner_keys[0]);
    send_request(CMD_REMOVE, 32'sd0);
    send_request(CMD_REMOVE, 32'sd0);
    send_request(CMD_NOP, -32'sd1);
    send_request(CMD_NOP, 32'sd0);

    // capacity below the count
    write_capacity(2);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sd1);
    send_request(CMD_SEARCH, 32'sd1);
    send_request(CMD_REMOVE, corner_keys[1]);
    send_request(CMD_INSERT, 32'sd2);
    send_request(CMD_REMOVE, -32'sd1);
    send_request(CMD_INSERT, corner_keys[0]);

    // random phases
    write_capacity(127);
    run_phase(260, 70, 15, 1'b0);

    send_idle = 69;
    run_phase(240, 40, 30, 1'b1);

    write_capacity(0);
    send_idle  = 0;
    recv_stall = 69;
    run_phase(160, 40, 30, 1'b0);

    write_capacity(10);
    send_idle  = 17;
    recv_stall = 17;
    run_phase(260, 50, 25, 1'b0);

    write_capacity(64);
    send_idle  = 0;
    recv_stall = 0;
    run_phase(300, 65, 20, 1'b0);

    write_capacity(33);
    send_idle  = 17;
    recv_stall = 17;
    run_phase(280, 35, 30, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sorted_set_table_top.f
+incdir+src
src/sst_pkg.sv
src/sst_cell.sv
src/sst_ctrl.sv
src/sorted_set_table_top.sv
tb/sv/sorted_set_table_top_tb.sv
